@@ rtl/core/accel_offset_moving_average_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the accelerometer offset moving average block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ACCEL_OFFSET_MOVING_AVERAGE_TOP_DEFINES_SVH
`define ACCEL_OFFSET_MOVING_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication
`define AOMA_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AOMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/aoma_pkg.sv @@
// ---------------------------------------------------------------------------
// aoma_pkg
// Shared types and defaults for the accelerometer offset moving average.
// ---------------------------------------------------------------------------
package aoma_pkg;

	localparam int AXES              = 3;
	localparam int SAMPLE_W          = 16;
	localparam int CORR_W            = 17;
	localparam int WINDOW_DEF        = 10;
	localparam int CALIB_SAMPLES_DEF = 150;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [CORR_W-1:0]   corr_t;
	typedef logic [AXES-1:0][SAMPLE_W-1:0] triple_t;

	typedef struct packed {
		logic step;
		logic cal;
	} aoma_ctrl_t;

endpackage

@@ rtl/core/aoma_if.sv @@
// ---------------------------------------------------------------------------
// aoma_sample_if / aoma_result_if
// Valid/ready channels for input samples and corrected results.
// ---------------------------------------------------------------------------
interface aoma_sample_if;
	import aoma_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_x;
	sample_t sample_y;
	sample_t sample_z;

	modport source (output valid, sample_x, sample_y, sample_z, input ready);
	modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface aoma_result_if;
	import aoma_pkg::*;

	logic  valid;
	logic  ready;
	corr_t corrected_x;
	corr_t corrected_y;
	corr_t corrected_z;
	logic  calibrating;

	modport source (output valid, corrected_x, corrected_y, corrected_z, calibrating,
		input ready);
	modport sink   (input valid, corrected_x, corrected_y, corrected_z, calibrating,
		output ready);
endinterface

@@ rtl/core/aoma_div_const.sv @@
// ---------------------------------------------------------------------------
// aoma_div_const
// Signed divide by a constant, truncating toward zero, via reciprocal multiply.
// ---------------------------------------------------------------------------
module aoma_div_const #(
	parameter int DIVISOR = aoma_pkg::WINDOW_DEF
) (
	input  aoma_pkg::corr_t num,
	output aoma_pkg::corr_t quo
);
	import aoma_pkg::*;

	localparam int L       = $clog2(DIVISOR);
	localparam int SHIFT   = CORR_W + L;
	localparam int RECIP_W = CORR_W + 2;
	localparam int PROD_W  = CORR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) / DIVISOR) + 1);

	logic              neg;
	logic [CORR_W-1:0] mag;
	logic [CORR_W-1:0] q_mag;
	logic [PROD_W-1:0] prod;

	// exact floor for any magnitude below 2^CORR_W
	always_comb begin
		neg   = num[CORR_W-1];
		mag   = neg ? CORR_W'(-num) : CORR_W'(num);
		prod  = PROD_W'(mag) * PROD_W'(RECIP);
		q_mag = CORR_W'(prod >> SHIFT);
		quo   = neg ? -$signed(q_mag) : $signed(q_mag);
	end

endmodule

@@ rtl/core/aoma_axis.sv @@
// ---------------------------------------------------------------------------
// aoma_axis
// One axis: offset and average accumulators and the corrected output.
// ---------------------------------------------------------------------------
module aoma_axis #(
	parameter int WINDOW        = aoma_pkg::WINDOW_DEF,
	parameter int CALIB_SAMPLES = aoma_pkg::CALIB_SAMPLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aoma_pkg::aoma_ctrl_t ctrl,
	input  aoma_pkg::sample_t    sample,
	input  aoma_pkg::sample_t    old,
	output aoma_pkg::corr_t      corrected
);
	import aoma_pkg::*;

	sample_t avg_q;
	sample_t off_q;
	sample_t avg_nxt;
	sample_t off_nxt;
	corr_t   diff;
	corr_t   cal_quo;
	corr_t   win_quo;

	assign diff = corr_t'(sample) - corr_t'(old);

	aoma_div_const #(.DIVISOR(CALIB_SAMPLES)) u_div_cal (
		.num(corr_t'(sample)),
		.quo(cal_quo)
	);

	aoma_div_const #(.DIVISOR(WINDOW)) u_div_win (
		.num(diff),
		.quo(win_quo)
	);

	always_comb begin
		off_nxt   = sample_t'(off_q + $signed(cal_quo[SAMPLE_W-1:0]));
		avg_nxt   = sample_t'(avg_q + $signed(win_quo[SAMPLE_W-1:0]));
		corrected = ctrl.cal ? corr_t'(avg_q) - corr_t'(off_nxt)
		                     : corr_t'(avg_nxt) - corr_t'(off_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			off_q <= '0;
		end else if (ctrl.step) begin
			if (ctrl.cal) begin
				off_q <= off_nxt;
			end else begin
				avg_q <= avg_nxt;
			end
		end
	end

endmodule

@@ rtl/core/aoma_ring.sv @@
// ---------------------------------------------------------------------------
// aoma_ring
// Sample history ring: memory, write slot, valid bits and registered read.
// ---------------------------------------------------------------------------
module aoma_ring #(
	parameter int WINDOW = aoma_pkg::WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  aoma_pkg::triple_t wr_data,
	output aoma_pkg::triple_t old
);
	import aoma_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW);

	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_nxt;
	logic [SLOT_W-1:0] rd_addr;
	logic [WINDOW-1:0] valid_q;
	logic              rd_valid_q;
	triple_t           rd_data_q;
	triple_t           mem [WINDOW];

	// read port always tracks the slot the next transaction will evict
	always_comb begin
		slot_nxt = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
		rd_addr  = push ? slot_nxt : slot_q;
		old      = rd_valid_q ? rd_data_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (push) begin
				slot_q          <= slot_nxt;
				valid_q[slot_q] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[slot_q] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

@@ rtl/core/accel_offset_moving_average_top.sv @@
// ---------------------------------------------------------------------------
// accel_offset_moving_average_top
// Accelerometer offset calibration followed by a moving average per axis.
//
//   channel  | dir | payload
//   samples  | in  | sample_x, sample_y, sample_z
//   results  | out | corrected_x, corrected_y, corrected_z, calibrating
//
// One transaction per cycle unless results stall; a sample passes through the
// input stage, then the result register. Each axis does a reciprocal multiply,
// an add and a subtract; averaging also subtracts the evicted sample first.
// Reset clears the ring valid bits, slot, average, offset and counter at once.
// A stalled result holds; the input stage can take one sample and holds it too.
// ---------------------------------------------------------------------------
module accel_offset_moving_average_top #(
	parameter int WINDOW        = aoma_pkg::WINDOW_DEF,
	parameter int CALIB_SAMPLES = aoma_pkg::CALIB_SAMPLES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	aoma_sample_if.sink  samples,
	aoma_result_if.source results
);
	import aoma_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);

	logic             valid_s1;
	triple_t          sample_s1;
	logic [CNT_W-1:0] calib_seen_q;
	logic             cal;
	logic             step;
	aoma_ctrl_t       ctrl;
	triple_t          old;
	corr_t            corr [AXES];
	logic             res_valid_q;
	corr_t            res_corr_q [AXES];
	logic             res_cal_q;

	assign cal           = calib_seen_q < CNT_W'(CALIB_SAMPLES);
	assign step          = valid_s1 && (!res_valid_q || results.ready);
	assign ctrl          = '{step: step, cal: cal};
	assign samples.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= {samples.sample_z, samples.sample_y, samples.sample_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_seen_q <= '0;
		end else if (step && cal) begin
			calib_seen_q <= calib_seen_q + 1'b1;
		end
	end

	aoma_ring #(.WINDOW(WINDOW)) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step && !cal),
		.wr_data(sample_s1),
		.old    (old)
	);

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		aoma_axis #(
			.WINDOW       (WINDOW),
			.CALIB_SAMPLES(CALIB_SAMPLES)
		) u_axis (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sample   ($signed(sample_s1[a])),
			.old      ($signed(old[a])),
			.corrected(corr[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_corr_q <= corr;
			res_cal_q  <= cal;
		end
	end

	assign results.valid       = res_valid_q;
	assign results.corrected_x = res_corr_q[0];
	assign results.corrected_y = res_corr_q[1];
	assign results.corrected_z = res_corr_q[2];
	assign results.calibrating = res_cal_q;

endmodule

@@ rtl/core/aoma_checker.sv @@
// ---------------------------------------------------------------------------
// aoma_checker
// Port-level checks on the accelerometer offset moving average top level.
// ---------------------------------------------------------------------------
`include "accel_offset_moving_average_top_defines.svh"

module aoma_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_calibrating
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] inflight_q;
	logic       run_seen_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			run_seen_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
			if (out_acc && !out_calibrating) begin
				run_seen_q <= 1'b1;
			end
		end
	end

	`AOMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`AOMA_ASSERT_IMPLY(a_inflight_max, 1'b1, inflight_q <= 3'd2, "more than two transactions held")
	`AOMA_ASSERT_IMPLY(a_no_invent, out_valid, inflight_q != 3'd0, "result without input")
	`AOMA_ASSERT_IMPLY(a_cal_done, out_acc && run_seen_q, !out_calibrating, "calibration resumed")

endmodule

bind accel_offset_moving_average_top aoma_checker u_aoma_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_calibrating(results.calibrating)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for accel_offset_moving_average_top. A directed table covers the
// calibration phase and sample extremes; random bursts then run the block
// through calibration into the moving average, with ring wrap and accumulator
// overflow. Every result is checked against an in-order queue of predictions,
// with random idling on both channels, a long result stall and a drain pause.
// ---------------------------------------------------------------------------
module tb_top;
	import aoma_pkg::*;

	localparam int WINDOW        = WINDOW_DEF;
	localparam int CALIB_SAMPLES = CALIB_SAMPLES_DEF;
	localparam int RANDOM_ITEMS  = 900;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLDOFF_LEN   = 300;

	typedef struct packed {
		corr_t x;
		corr_t y;
		corr_t z;
		logic  cal;
	} accel_out_t;

	typedef struct {
		sample_t    x;
		sample_t    y;
		sample_t    z;
		bit         typed;
		accel_out_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	aoma_sample_if smp();
	aoma_result_if res();

	accel_offset_moving_average_top #(
		.WINDOW(WINDOW),
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(smp),
		.results(res)
	);

	// predictor state
	sample_t ring [WINDOW][AXES];
	sample_t avg_acc [AXES];
	sample_t off_acc [AXES];
	int      ring_pos;
	int      cal_count;

	accel_out_t pending_outputs [$];
	stim_row_t  stim_table [$];
	int         mismatches;
	int         results_seen;
	bit         steady;

	function automatic accel_out_t filter_step(sample_t sx, sample_t sy, sample_t sz);
		sample_t    s [AXES];
		int         d;
		logic       cal;
		accel_out_t r;
		s[0] = sx;
		s[1] = sy;
		s[2] = sz;
		cal = (cal_count < CALIB_SAMPLES);
		if (cal) begin
			for (int a = 0; a < AXES; a++)
				off_acc[a] = sample_t'(int'(off_acc[a]) + int'(s[a]) / CALIB_SAMPLES);
			cal_count++;
		end else begin
			for (int a = 0; a < AXES; a++) begin
				d = int'(s[a]) - int'(ring[ring_pos][a]);
				ring[ring_pos][a] = s[a];
				avg_acc[a] = sample_t'(int'(avg_acc[a]) + d / WINDOW);
			end
			ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
		end
		r.x   = corr_t'(int'(avg_acc[0]) - int'(off_acc[0]));
		r.y   = corr_t'(int'(avg_acc[1]) - int'(off_acc[1]));
		r.z   = corr_t'(int'(avg_acc[2]) - int'(off_acc[2]));
		r.cal = cal;
		return r;
	endfunction

	function automatic void add_row(int x, int y, int z, bit typed,
			int ex = 0, int ey = 0, int ez = 0, bit ecal = 1'b0);
		stim_row_t row;
		row.x        = sample_t'(x);
		row.y        = sample_t'(y);
		row.z        = sample_t'(z);
		row.typed    = typed;
		row.want.x   = corr_t'(ex);
		row.want.y   = corr_t'(ey);
		row.want.z   = corr_t'(ez);
		row.want.cal = ecal;
		stim_table.push_back(row);
	endfunction

	function automatic sample_t rand_axis(int mode);
		sample_t v;
		case (mode)
			0: v = sample_t'($urandom);
			1: begin
				case ($urandom_range(0, 4))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					2: v = -16'sd1;
					3: v = 16'sd0;
					default: v = 16'sd1;
				endcase
			end
			2: v = sample_t'($urandom_range(0, 600) - 300);
			default: v = sample_t'($urandom_range(0, 3) * 16'sh5555);
		endcase
		return v;
	endfunction

	task automatic send_sample(sample_t x, sample_t y, sample_t z, bit typed, accel_out_t want);
		accel_out_t pred;
		if (!steady) begin
			while ($urandom_range(0, 99) < 35) begin
				smp.valid <= 1'b0;
				@(posedge clk);
			end
		end
		smp.valid    <= 1'b1;
		smp.sample_x <= x;
		smp.sample_y <= y;
		smp.sample_z <= z;
		do @(posedge clk); while (!smp.ready);
		pred = filter_step(x, y, z);
		pending_outputs.push_back(typed ? want : pred);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side
	initial begin
		accel_out_t exp_out;
		int         hold_left;
		bit         held;
		res.ready <= 1'b0;
		hold_left = 0;
		held      = 1'b0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			if (!held && results_seen == 250) begin
				held      = 1'b1;
				hold_left = HOLDOFF_LEN;
			end
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else begin
				res.ready <= steady || ($urandom_range(0, 99) >= 35);
			end
			@(posedge clk);
			if (res.valid && res.ready) begin
				results_seen++;
				if (pending_outputs.size() == 0) begin
					$error("unexpected result transaction");
					mismatches++;
				end else begin
					exp_out = pending_outputs.pop_front();
					if (res.corrected_x !== exp_out.x) begin
						$error("corrected_x: expected %0d, got %0d", exp_out.x, res.corrected_x);
						mismatches++;
					end
					if (res.corrected_y !== exp_out.y) begin
						$error("corrected_y: expected %0d, got %0d", exp_out.y, res.corrected_y);
						mismatches++;
					end
					if (res.corrected_z !== exp_out.z) begin
						$error("corrected_z: expected %0d, got %0d", exp_out.z, res.corrected_z);
						mismatches++;
					end
					if (res.calibrating !== exp_out.cal) begin
						$error("calibrating: expected %0b, got %0b", exp_out.cal,
							res.calibrating);
						mismatches++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((smp.valid && smp.ready) || (res.valid && res.ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// stimulus
	initial begin
		accel_out_t none;
		int         mode;
		none       = '0;
		mismatches = 0;
		steady     = 1'b0;
		ring_pos   = 0;
		cal_count  = 0;
		foreach (ring[i, a])
			ring[i][a] = '0;
		foreach (avg_acc[a]) begin
			avg_acc[a] = '0;
			off_acc[a] = '0;
		end
		arst_n       <= 1'b0;
		smp.valid    <= 1'b0;
		smp.sample_x <= '0;
		smp.sample_y <= '0;
		smp.sample_z <= '0;

		// offsets accumulate from zero; corrected = -offset while calibrating
		add_row(0, 0, 0, 1, 0, 0, 0, 1);
		add_row(32767, -32768, 149, 1, -218, 218, 0, 1);
		add_row(-32768, 32767, -149, 1, 0, 0, 0, 1);
		add_row(150, -150, 300, 1, -1, 1, -2, 1);
		add_row(-151, 151, -299, 1, 0, 0, -1, 1);
		add_row(-1, 1, -1, 0);
		add_row(32767, 32767, 32767, 0);
		add_row(-32768, -32768, -32768, 0);
		add_row(16'h5555, 16'haaaa, 16'h5555, 0);
		add_row(16'haaaa, 16'h5555, 16'haaaa, 0);
		add_row(-150, 150, -150, 0);
		add_row(299, -299, 450, 0);
		add_row(16'h00ff, 16'hff00, 16'h0f0f, 0);
		add_row(16'hf0f0, 16'h7ffe, 16'h8001, 0);
		add_row(32767, 0, -32768, 0);
		add_row(0, -32768, 32767, 0);
		add_row(1234, -4321, 9999, 0);
		add_row(-12345, 23456, -30000, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_sample(stim_table[i].x, stim_table[i].y, stim_table[i].z,
				stim_table[i].typed, stim_table[i].want);

		mode = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 16 == 0)
				mode = $urandom_range(0, 3);
			steady = (n >= 350 && n < 500);
			if (n == 650) begin
				smp.valid <= 1'b0;
				while (pending_outputs.size() != 0)
					@(posedge clk);
			end
			send_sample(rand_axis(mode), rand_axis(mode), rand_axis(mode), 1'b0, none);
		end
		steady = 1'b0;
		smp.valid <= 1'b0;

		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ accel_offset_moving_average_top.f @@
+incdir+rtl/core
rtl/core/aoma_pkg.sv
rtl/core/aoma_if.sv
rtl/core/aoma_div_const.sv
rtl/core/aoma_axis.sv
rtl/core/aoma_ring.sv
rtl/core/accel_offset_moving_average_top.sv
rtl/core/aoma_checker.sv
sim/tb_top.sv
